[rtl/page_frame_allocator_fifo_evict_assert.svh]
// Assertion macros for the page frame allocator.
// Used by the datapath; expects clk and rst in scope.
`ifndef PAGE_FRAME_ALLOCATOR_FIFO_EVICT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_FIFO_EVICT_ASSERT_SVH

// condition holds at every edge out of reset
`define PFA_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define PFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pfa_pkg.sv]
// Types and codes shared by the page frame allocator modules.
// No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_VICTIM = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_RUN    = 2'd1;
  localparam logic [1:0] ST_NO_VICTIM = 2'd2;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd3;

  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_FRAMES_IN_USE = 1'd0;
  localparam logic [CFG_IW-1:0] REG_BASE_ADDRESS  = 1'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_kernel;
    logic [8:0]  page_count;
    logic [31:0] owner_tag;
    logic [31:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] frame_address;
    logic [7:0]  frame_number;
    logic [31:0] victim_owner;
  } result_t;

  typedef struct packed {
    logic used;
    logic kernel;
    logic cont;
  } flags_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_KWRITE, S_UWRITE,
    S_FRD, S_FEV, S_FNX, S_VRD, S_VWR
  } state_t;

  typedef enum logic [3:0] {
    ACT_IDLE, ACT_CLEAR, ACT_LATCH, ACT_DECODE, ACT_SCAN, ACT_KWRITE, ACT_UWRITE,
    ACT_FREE_RD, ACT_FREE_EV, ACT_FREE_NX, ACT_VIC_RD, ACT_VIC_WR
  } act_t;

  typedef enum logic [2:0] {
    RES_ALLOC_OK, RES_FREE_OK, RES_VIC_OK, RES_NOP,
    RES_NO_RUN, RES_NO_VICTIM, RES_BAD_ADDR
  } res_kind_t;

  typedef struct packed {
    act_t      act;
    logic      report;
    res_kind_t kind;
  } ctl_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       clear_last;
    logic       count_zero;
    logic       addr_bad;
    logic       oldest_none;
    logic       scan_found;
    logic       scan_empty;
    logic       kernel_run;
    logic       kw_last;
    logic       free_more;
  } dp_sts_t;

endpackage

[rtl/pfa_ctrl.sv]
// Sequencer of the page frame allocator: state machine issuing datapath actions.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pfa_pkg::dp_sts_t sts,
  output pfa_pkg::ctl_t    ctl
);
  import pfa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (sts.clear_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: begin
        unique case (sts.opcode)
          OP_ALLOC:  state_next = sts.count_zero ? S_IDLE : S_SCAN;
          OP_FREE:   state_next = sts.addr_bad ? S_IDLE : S_FRD;
          OP_VICTIM: state_next = sts.oldest_none ? S_IDLE : S_VRD;
          default:   state_next = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts.scan_found) state_next = sts.kernel_run ? S_KWRITE : S_UWRITE;
        else if (sts.scan_empty) state_next = S_IDLE;
      end
      S_KWRITE: if (sts.kw_last) state_next = S_IDLE;
      S_UWRITE: state_next = S_IDLE;
      S_FRD:    state_next = S_FEV;
      S_FEV:    state_next = S_FNX;
      S_FNX:    state_next = sts.free_more ? S_FRD : S_IDLE;
      S_VRD:    state_next = S_VWR;
      S_VWR:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.act    = ACT_IDLE;
    ctl.report = 1'b0;
    ctl.kind   = RES_NOP;
    busy       = (state != S_IDLE);
    unique case (state)
      S_CLEAR: ctl.act = ACT_CLEAR;
      S_IDLE:  ctl.act = start ? ACT_LATCH : ACT_IDLE;
      S_DECODE: begin
        ctl.act = ACT_DECODE;
        unique case (sts.opcode)
          OP_ALLOC: begin
            ctl.report = sts.count_zero;
            ctl.kind   = RES_NO_RUN;
          end
          OP_FREE: begin
            ctl.report = sts.addr_bad;
            ctl.kind   = RES_BAD_ADDR;
          end
          OP_VICTIM: begin
            ctl.report = sts.oldest_none;
            ctl.kind   = RES_NO_VICTIM;
          end
          default: begin
            ctl.report = 1'b1;
            ctl.kind   = RES_NOP;
          end
        endcase
      end
      S_SCAN: begin
        ctl.act    = ACT_SCAN;
        ctl.report = !sts.scan_found && sts.scan_empty;
        ctl.kind   = RES_NO_RUN;
      end
      S_KWRITE: begin
        ctl.act    = ACT_KWRITE;
        ctl.report = sts.kw_last;
        ctl.kind   = RES_ALLOC_OK;
      end
      S_UWRITE: begin
        ctl.act    = ACT_UWRITE;
        ctl.report = 1'b1;
        ctl.kind   = RES_ALLOC_OK;
      end
      S_FRD: ctl.act = ACT_FREE_RD;
      S_FEV: ctl.act = ACT_FREE_EV;
      S_FNX: begin
        ctl.act    = ACT_FREE_NX;
        ctl.report = !sts.free_more;
        ctl.kind   = RES_FREE_OK;
      end
      S_VRD: ctl.act = ACT_VIC_RD;
      S_VWR: begin
        ctl.act    = ACT_VIC_WR;
        ctl.report = 1'b1;
        ctl.kind   = RES_VIC_OK;
      end
      default: ctl.act = ACT_IDLE;
    endcase
  end

endmodule

[rtl/pfa_dp.sv]
// Datapath of the page frame allocator: config registers, frame tables, age chain
// ends, scan and walk counters, result register. Depends on pfa_pkg and the macro header.
`timescale 1ns / 1ps
`include "page_frame_allocator_fifo_evict_assert.svh"

module pfa_dp #(
  parameter int MAX_FRAMES = 256,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pfa_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  pfa_pkg::cmd_t               cmd,
  input  pfa_pkg::ctl_t               ctl,
  output pfa_pkg::dp_sts_t            sts,
  output logic                        done,
  output pfa_pkg::result_t            result
);
  import pfa_pkg::*;

  localparam int IW  = $clog2(MAX_FRAMES + 1);
  localparam int AW  = $clog2(MAX_FRAMES);
  localparam int PSH = $clog2(PAGE_BYTES);
  localparam logic [IW-1:0] NONE = IW'(MAX_FRAMES);

  logic [8:0]    frames_in_use;
  logic [31:0]   base_address;
  cmd_t          cmd_q;
  logic [8:0]    count_eff;
  logic [IW-1:0] ptr, rd_idx, run_start, fptr, oldest, newest;
  logic [8:0]    run_len, wcnt;
  logic          rd_pend;

  // frame tables
  flags_t        flags_mem [MAX_FRAMES];
  logic [IW-1:0] older_mem [MAX_FRAMES];
  logic [IW-1:0] newer_mem [MAX_FRAMES];
  logic [31:0]   owner_mem [MAX_FRAMES];
  flags_t        flags_q;
  logic [IW-1:0] older_q, newer_q;
  logic [31:0]   owner_q;

  logic          re;
  logic [AW-1:0] ra;
  logic          fl_we, ol_we, nw_we, ow_we;
  logic [AW-1:0] fl_wa, ol_wa, nw_wa, ow_wa;
  flags_t        fl_wd;
  logic [IW-1:0] ol_wd, nw_wd;

  logic [IW-1:0] lim;
  logic [31:0]   off;
  logic          hit, issue, unlink;
  result_t       result_next;

  assign lim = (32'(frames_in_use) < 32'(MAX_FRAMES)) ? IW'(frames_in_use) : NONE;
  assign off = cmd_q.free_address - base_address;

  assign hit    = rd_pend && !flags_q.used && (10'(run_len) + 10'd1 == 10'(count_eff));
  assign issue  = (ctl.act == ACT_SCAN) && !hit && (ptr < lim);
  assign unlink = !flags_q.kernel && (older_q != NONE || oldest == fptr);

  always_comb begin
    sts.opcode      = cmd_q.opcode;
    sts.clear_last  = (32'(ptr) == 32'(MAX_FRAMES - 1));
    sts.count_zero  = (count_eff == 9'd0);
    sts.addr_bad    = (cmd_q.free_address < base_address) || (off[PSH-1:0] != '0) ||
                      ((off >> PSH) >= 32'(lim));
    sts.oldest_none = (oldest == NONE);
    sts.scan_found  = hit;
    sts.scan_empty  = !rd_pend && (ptr >= lim);
    sts.kernel_run  = cmd_q.is_kernel;
    sts.kw_last     = (10'(wcnt) + 10'd1 == 10'(count_eff));
    sts.free_more   = flags_q.cont && ((IW+1)'(fptr) + (IW+1)'(1) < (IW+1)'(lim));
  end

  // read and write ports of the tables
  always_comb begin
    re    = 1'b0;
    ra    = ptr[AW-1:0];
    fl_we = 1'b0; fl_wa = ptr[AW-1:0]; fl_wd = '0;
    ol_we = 1'b0; ol_wa = ptr[AW-1:0]; ol_wd = NONE;
    nw_we = 1'b0; nw_wa = ptr[AW-1:0]; nw_wd = NONE;
    ow_we = 1'b0; ow_wa = run_start[AW-1:0];
    case (ctl.act)
      ACT_CLEAR: begin
        fl_we = 1'b1;
        ol_we = 1'b1;
        nw_we = 1'b1;
      end
      ACT_SCAN: begin
        re = issue;
      end
      ACT_KWRITE: begin
        fl_we = 1'b1;
        fl_wa = AW'(32'(run_start) + 32'(wcnt));
        fl_wd = '{used: 1'b1, kernel: 1'b1,
                  cont: (10'(wcnt) + 10'd1 < 10'(count_eff))};
      end
      ACT_UWRITE: begin
        fl_we = 1'b1;
        fl_wa = run_start[AW-1:0];
        fl_wd = '{used: 1'b1, kernel: 1'b0, cont: 1'b0};
        ol_we = 1'b1;
        ol_wa = run_start[AW-1:0];
        ol_wd = newest;
        nw_we = (newest != NONE);
        nw_wa = newest[AW-1:0];
        nw_wd = run_start;
        ow_we = 1'b1;
      end
      ACT_FREE_RD: begin
        re = 1'b1;
        ra = fptr[AW-1:0];
      end
      ACT_FREE_EV: begin
        fl_we = 1'b1;
        fl_wa = fptr[AW-1:0];
        ol_we = unlink && (newer_q != NONE);
        ol_wa = newer_q[AW-1:0];
        ol_wd = older_q;
        nw_we = unlink && (older_q != NONE);
        nw_wa = older_q[AW-1:0];
        nw_wd = newer_q;
      end
      ACT_FREE_NX: begin
        ol_we = 1'b1;
        ol_wa = fptr[AW-1:0];
        nw_we = 1'b1;
        nw_wa = fptr[AW-1:0];
      end
      ACT_VIC_RD: begin
        re = 1'b1;
        ra = oldest[AW-1:0];
      end
      ACT_VIC_WR: begin
        ol_we = (newer_q != NONE);
        ol_wa = newer_q[AW-1:0];
        nw_we = 1'b1;
        nw_wa = oldest[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fl_we) flags_mem[fl_wa] <= fl_wd;
    if (re) flags_q <= flags_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (ol_we) older_mem[ol_wa] <= ol_wd;
    if (re) older_q <= older_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (nw_we) newer_mem[nw_wa] <= nw_wd;
    if (re) newer_q <= newer_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (ow_we) owner_mem[ow_wa] <= cmd_q.owner_tag;
    if (re) owner_q <= owner_mem[ra];
  end

  always_comb begin
    result_next = '0;
    case (ctl.kind)
      RES_ALLOC_OK: begin
        result_next.frame_address = base_address + (32'(run_start) << PSH);
        result_next.frame_number  = 8'(run_start);
      end
      RES_FREE_OK: begin
        result_next.frame_address = cmd_q.free_address;
        result_next.frame_number  = 8'(run_start);
      end
      RES_VIC_OK: begin
        result_next.frame_address = base_address + (32'(oldest) << PSH);
        result_next.frame_number  = 8'(oldest);
        result_next.victim_owner  = owner_q;
      end
      RES_NO_RUN:    result_next.status = ST_NO_RUN;
      RES_NO_VICTIM: result_next.status = ST_NO_VICTIM;
      RES_BAD_ADDR:  result_next.status = ST_BAD_ADDR;
      default:       result_next.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 9'd256;
      base_address  <= '0;
      ptr           <= '0;
      rd_pend       <= 1'b0;
      oldest        <= NONE;
      newest        <= NONE;
      done          <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FRAMES_IN_USE) frames_in_use <= cfg_data[8:0];
        if (cfg_index == REG_BASE_ADDRESS) base_address <= cfg_data;
      end
      rd_pend <= issue;
      if (issue) rd_idx <= ptr;
      done <= ctl.report;
      if (ctl.report) result <= result_next;
      case (ctl.act)
        ACT_CLEAR: ptr <= ptr + IW'(1);
        ACT_LATCH: begin
          cmd_q     <= cmd;
          count_eff <= cmd.is_kernel ? cmd.page_count : 9'd1;
        end
        ACT_DECODE: begin
          ptr       <= '0;
          run_len   <= '0;
          wcnt      <= '0;
          fptr      <= IW'(off >> PSH);
          run_start <= IW'(off >> PSH);
        end
        ACT_SCAN: begin
          if (issue) ptr <= ptr + IW'(1);
          if (rd_pend) begin
            if (flags_q.used) begin
              run_len <= '0;
            end else begin
              if (run_len == 9'd0) run_start <= rd_idx;
              run_len <= run_len + 9'd1;
            end
          end
        end
        ACT_KWRITE: wcnt <= wcnt + 9'd1;
        ACT_UWRITE: begin
          if (oldest == NONE) oldest <= run_start;
          newest <= run_start;
        end
        ACT_FREE_EV: begin
          if (unlink) begin
            if (older_q == NONE) oldest <= newer_q;
            if (newer_q == NONE) newest <= older_q;
          end
        end
        ACT_FREE_NX: fptr <= fptr + IW'(1);
        ACT_VIC_WR: begin
          oldest <= newer_q;
          if (newest == oldest) newest <= NONE;
        end
        default: ;
      endcase
    end
  end

  `PFA_ASSERT_HOLD(a_chain_ends, (oldest == NONE) == (newest == NONE), "chain ends disagree")
  `PFA_ASSERT_NEXT(a_done_gap, done, !done, "result words back to back")
  `PFA_ASSERT_NEXT(a_scan_read, issue, rd_pend && rd_idx == $past(ptr), "scan read lost")

endmodule

[rtl/page_frame_allocator_fifo_evict.sv]
// Top level of the page frame allocator: sequencer plus datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dp.
//
//   channel   handshake             word
//   command   start & !busy         cmd (cmd_t)
//   result    done, one cycle       result (result_t)
//   config    cfg_write             cfg_index, cfg_data
//
// After reset a clearing pass over all MAX_FRAMES table entries runs with busy high.
// Allocate scans for a free run (one table read per scan cycle until a run fits) and
// fails when no run fits; a user frame is written alone, a kernel run frame by frame.
// Free walks the frames of a run; victim reports and unlinks the oldest user frame.
// The result is valid on done and held until the next result; the receiver cannot stall it.
`timescale 1ns / 1ps

module page_frame_allocator_fifo_evict #(
  parameter int MAX_FRAMES = 256,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  pfa_pkg::cmd_t              cmd,
  output logic                       done,
  output pfa_pkg::result_t           result,
  input  logic                       cfg_write,
  input  logic [pfa_pkg::CFG_IW-1:0] cfg_index,
  input  logic [31:0]                cfg_data
);
  import pfa_pkg::*;

  ctl_t    ctl;
  dp_sts_t sts;

  pfa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  pfa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .done      (done),
    .result    (result)
  );

endmodule
